/* sv/twm_pkg.sv */
package twm_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int HEIGHT_BITS = 16;

    localparam int IN_HEIGHT_W = 16;
    localparam int WATER_W     = 26;
    localparam logic [WATER_W-1:0] WATER_MAX = {WATER_W{1'b1}};

    localparam int HGT_W  = (HEIGHT_BITS < IN_HEIGHT_W) ? HEIGHT_BITS : IN_HEIGHT_W;
    localparam int POS_W  = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = POS_W;
    localparam int PROD_W = IDX_W + HGT_W;
    localparam int SUM_W  = POS_W + HGT_W;
    localparam int CMP_W  = (SUM_W > WATER_W) ? SUM_W : WATER_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [IDX_W-1:0] pos;
        logic [HGT_W-1:0] height;
        logic             take;
        logic             last;
    } t_bar_req;

    typedef struct packed {
        logic [IDX_W-1:0] pos;
        logic [HGT_W-1:0] hgt;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_READ,
        ST_MUL,
        ST_OUT
    } t_back_state;

endpackage

/* sv/twm_in_if.sv */
interface twm_in_if import twm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [IN_HEIGHT_W-1:0] height;
    logic                   last;

    modport source (output valid, output height, output last, input ready);
    modport sink   (input valid, input height, input last, output ready);
endinterface

/* sv/twm_out_if.sv */
interface twm_out_if import twm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [WATER_W-1:0] water;
    logic               overrun;

    modport source (output valid, output water, output overrun, input ready);
    modport sink   (input valid, input water, input overrun, output ready);
endinterface

/* sv/twm_front.sv */
module twm_front import twm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    twm_in_if.sink    i_bar,
    input  logic      i_q_full,
    output logic      o_push,
    output t_bar_req  o_req
);

    logic [POS_W-1:0] r_pos;
    logic             take;
    logic             accept;

    assign take        = r_pos < POS_W'(MAX_LEN);
    assign i_bar.ready = !i_q_full;
    assign accept      = i_bar.valid && !i_q_full;
    assign o_push      = accept;

    assign o_req.pos    = r_pos[IDX_W-1:0];
    assign o_req.height = i_bar.height[HGT_W-1:0];
    assign o_req.take   = take;
    assign o_req.last   = i_bar.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            if (i_bar.last) begin
                r_pos <= '0;
            end else if (take) begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

endmodule

/* sv/twm_queue.sv */
module twm_queue import twm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_bar_req  i_req,
    output logic      o_full,
    output logic      o_valid,
    output t_bar_req  o_req,
    input  logic      i_pop
);

    t_bar_req            r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic                do_pop;

    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_req   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

endmodule

/* sv/twm_back.sv */
module twm_back import twm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_bar_req  i_q_req,
    output logic      o_q_pop,
    twm_out_if.source o_res
);

    t_back_state        r_state;
    t_back_state        n_state;

    t_bar_req           r_bar;
    t_entry             r_top;
    t_entry             r_rd;
    t_entry             r_stack [MAX_LEN];
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;
    logic               r_dropped;
    logic [HGT_W-1:0]   r_floor;
    logic [IDX_W-1:0]   r_width;
    logic [HGT_W-1:0]   r_depth;
    logic [PROD_W-1:0]  r_prod;
    logic               r_pend;
    logic               r_out_valid;
    logic [WATER_W-1:0] r_water;
    logic               r_overrun;

    logic               pop_cond;
    logic               slot_free;
    logic               do_pop;
    logic               do_push;
    logic               rd_en;
    logic               load_out;
    logic [CNT_W-1:0]   rd_cnt;
    logic [HGT_W-1:0]   bound;
    logic [CMP_W-1:0]   sum_ext;

    assign pop_cond  = (r_count != '0) && (r_top.hgt < r_bar.height);
    assign slot_free = !r_out_valid || o_res.ready;
    assign rd_cnt    = r_count - CNT_W'(2);
    assign bound     = (r_rd.hgt < r_bar.height) ? r_rd.hgt : r_bar.height;
    assign sum_ext   = CMP_W'(r_sum);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_req.take) begin
                        n_state = ST_CMP;
                    end else if (i_q_req.last) begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_CMP: begin
                if (pop_cond) begin
                    n_state = (r_count == CNT_W'(1)) ? ST_CMP : ST_READ;
                end else begin
                    n_state = r_bar.last ? ST_OUT : ST_IDLE;
                end
            end
            ST_READ: n_state = ST_MUL;
            ST_MUL:  n_state = ST_CMP;
            ST_OUT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: o_q_pop = 1'b1;
            ST_CMP: begin
                do_pop  = pop_cond;
                do_push = !pop_cond;
                rd_en   = pop_cond && (r_count != CNT_W'(1));
            end
            ST_READ, ST_MUL: ;
            ST_OUT:  load_out = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_dropped   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_pend) begin
                r_sum  <= r_sum + SUM_W'(r_prod);
                r_pend <= 1'b0;
            end
            if (r_state == ST_MUL) begin
                r_pend <= 1'b1;
            end
            if (o_q_pop && i_q_valid && !i_q_req.take) begin
                r_dropped <= 1'b1;
            end
            if (do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (do_push) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_sum       <= '0;
                r_count     <= '0;
                r_dropped   <= 1'b0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_valid) begin
            r_bar <= i_q_req;
        end
        if (do_pop) begin
            r_floor <= r_top.hgt;
        end
        if (r_state == ST_READ) begin
            r_top   <= r_rd;
            r_width <= r_bar.pos - r_rd.pos - IDX_W'(1);
            r_depth <= bound - r_floor;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_width) * PROD_W'(r_depth);
        end
        if (do_push) begin
            r_top.pos <= r_bar.pos;
            r_top.hgt <= r_bar.height;
        end
        if (load_out) begin
            r_overrun <= r_dropped;
            if (sum_ext > CMP_W'(WATER_MAX)) begin
                r_water <= WATER_MAX;
            end else begin
                r_water <= sum_ext[WATER_W-1:0];
            end
        end
    end

    // stack memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_stack[r_count[IDX_W-1:0]] <= '{pos: r_bar.pos, hgt: r_bar.height};
        end
        if (rd_en) begin
            r_rd <= r_stack[rd_cnt[IDX_W-1:0]];
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.water   = r_water;
    assign o_res.overrun = r_overrun;

endmodule

/* sv/trapped_water_monotonic_stack.sv */
// Trapped water over a run of bars. Each request carries one bar height and a last
// flag; the request with last set closes the run and yields one result with the total
// water of the run, saturated at the field width, and an overrun bit when bars past
// the first 1024 were dropped. A front stage numbers and classifies bars and hands
// them through a four-entry queue to a back sequencer that keeps the monotonic stack
// in a 1024 x 26 memory with one write and one registered read port. A bar that pops
// nothing is compared and pushed; each popped entry that leaves a wall beneath it adds
// a stack read, a width and depth step and a multiply, while a pop that empties the
// stack only drops the entry. A dropped bar only marks the overrun, and the closing bar
// then loads the result register once the output slot is free. Each bar is pushed once
// and popped at most once. The stack needs no clearing after reset.
module trapped_water_monotonic_stack import twm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    twm_in_if.sink    i_bar,
    twm_out_if.source o_res
);

    logic     push;
    t_bar_req push_req;
    logic     q_full;
    logic     q_valid;
    t_bar_req q_req;
    logic     q_pop;

    twm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bar    (i_bar),
        .i_q_full (q_full),
        .o_push   (push),
        .o_req    (push_req)
    );

    twm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (q_pop)
    );

    twm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_req   (q_req),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule

/* sv/twm_checker.sv */
module twm_checker import twm_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [WATER_W-1:0] i_water,
    input logic               i_overrun
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_water) && $stable(i_overrun))
        else $error("result payload changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind trapped_water_monotonic_stack twm_checker u_twm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_bar.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_water     (o_res.water),
    .i_overrun   (o_res.overrun)
);
